// ----- hw/rtl/cpd_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and helpers for the cascaded PID controller.
// No dependencies; imported by every other file of the block but cpd_if.
package cpd_pkg;

    localparam int FRAC_BITS      = 8;
    localparam int INTEGRAL_WIDTH = 40;
    localparam int ACC_W          = 64;
    // serial multiplier: one gain bit per cycle
    localparam int MUL_B_W        = 16;
    localparam int MUL_CNT_W      = $clog2(MUL_B_W + 1);
    // serial divider: one quotient bit per cycle
    localparam int DIV_W          = 56;
    localparam int DIV_CNT_W      = $clog2(DIV_W + 1);
    localparam int DEN_W          = 10 + FRAC_BITS;

    localparam int MS_PER_S       = 1000;
    localparam int DRIVE_MIN      = -300;
    localparam int DRIVE_MAX      = 700;
    localparam int PULSE_MIN      = 1000;
    localparam int PULSE_MAX      = 2000;

    // register indexes on the configuration port
    localparam logic [2:0] REG_SETPOINT = 3'd0;
    localparam logic [2:0] REG_KP_OUTER = 3'd1;
    localparam logic [2:0] REG_KP_INNER = 3'd2;
    localparam logic [2:0] REG_KI_INNER = 3'd3;
    localparam logic [2:0] REG_KD_INNER = 3'd4;
    localparam logic [2:0] REG_THROTTLE = 3'd5;
    localparam logic [2:0] REG_WINDOW   = 3'd6;

    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] a;
        logic [MUL_B_W-1:0]      b;
    } t_mul_req;

    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] num;
        logic [DEN_W-1:0]        den;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [ACC_W-1:0] value;
    } t_unit_rsp;

endpackage

// ----- hw/rtl/cpd_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input beat and the result beat.
// Depends on nothing.
interface cpd_in_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] pitch_angle;
    logic signed [15:0] pitch_rate;
    logic [7:0]         elapsed_ms;
    logic               outer_due;
    logic               inner_due;
    modport source (output valid, pitch_angle, pitch_rate, elapsed_ms, outer_due,
                    inner_due, input ready);
    modport sink   (input valid, pitch_angle, pitch_rate, elapsed_ms, outer_due,
                    inner_due, output ready);
endinterface

interface cpd_out_if;
    logic               valid;
    logic               ready;
    logic signed [10:0] drive;
    logic [10:0]        pulse_a;
    logic [10:0]        pulse_b;
    logic               derivative_skipped;
    modport source (output valid, drive, pulse_a, pulse_b, derivative_skipped,
                    input ready);
    modport sink   (input valid, drive, pulse_a, pulse_b, derivative_skipped,
                    output ready);
endinterface

// ----- hw/rtl/cpd_mul.sv -----
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier: signed multiplicand times unsigned gain.
// Depends on cpd_pkg.
module cpd_mul
    import cpd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_mul_req  i_req,
    output t_unit_rsp o_rsp
);

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [MUL_CNT_W-1:0]    r_cnt, n_cnt;
    logic signed [ACC_W-1:0] r_a, n_a;
    logic [MUL_B_W-1:0]      r_b, n_b;
    logic signed [ACC_W-1:0] r_acc, n_acc;

    // one gain bit per cycle, multiplicand shifts left
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        if (!r_busy && i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_a    = i_req.a;
            n_b    = i_req.b;
            n_acc  = '0;
        end else if (r_busy) begin
            if (r_b[0]) n_acc = r_acc + r_a;
            n_a   = r_a <<< 1;
            n_b   = r_b >> 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_acc;

endmodule

// ----- hw/rtl/cpd_div.sv -----
`timescale 1ns / 1ps
// Bit-serial restoring divider giving the floor quotient of a signed
// numerator by a positive divisor. Depends on cpd_pkg.
module cpd_div
    import cpd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_req  i_req,
    output t_unit_rsp o_rsp
);

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic                    r_fix, n_fix;
    logic                    r_neg, n_neg;
    logic [DIV_CNT_W-1:0]    r_cnt, n_cnt;
    logic [DIV_W-1:0]        r_q, n_q;
    logic [DEN_W-1:0]        r_rem, n_rem;
    logic [DEN_W-1:0]        r_den, n_den;
    logic signed [ACC_W-1:0] r_res, n_res;
    logic [ACC_W-1:0]        w_mag;
    logic [DEN_W:0]          w_sh;

    assign w_mag = i_req.num[ACC_W-1] ? ACC_W'(-i_req.num) : ACC_W'(i_req.num);
    assign w_sh  = {r_rem, r_q[DIV_W-1]};

    // quotient bits shift in where the numerator bits shift out
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_fix  = 1'b0;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        n_res  = r_res;
        if (!r_busy && !r_fix && i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_neg  = i_req.num[ACC_W-1];
            n_q    = w_mag[DIV_W-1:0];
            n_rem  = '0;
            n_den  = i_req.den;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = DEN_W'(w_sh - {1'b0, r_den});
                n_q   = {r_q[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = w_sh[DEN_W-1:0];
                n_q   = {r_q[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                n_busy = 1'b0;
                n_fix  = 1'b1;
            end
        end else if (r_fix) begin
            // negative numerator: floor rounds down past a remainder
            if (r_neg)
                n_res = -$signed(ACC_W'(r_q)) - ((r_rem != '0) ? 1 : 0);
            else
                n_res = $signed(ACC_W'(r_q));
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_fix  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_fix  <= n_fix;
            r_cnt  <= n_cnt;
        end
        r_neg <= n_neg;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
        r_res <= n_res;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_res;

endmodule

// ----- hw/rtl/cascaded_pid_dual_pwm.sv -----
`timescale 1ns / 1ps
// Cascaded angle/rate PID with two opposed motor pulses; top level.
// A beat with no loop due goes straight to the finish state; the outer loop
// adds one serial multiply; the inner loop adds up to four serial multiplies,
// two 56-bit serial divides, and the error and sum steps. One beat is in
// flight at a time: the next beat can be taken in the cycle after the result
// registers, and the result waits in the finish state while it is stalled.
// Synchronous active-low reset restores register defaults and zeroes state.
module cascaded_pid_dual_pwm
    import cpd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [16:0]   i_cfg_data,
    cpd_in_if.sink        i_in,
    cpd_out_if.source     o_out
);

    localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] HALF_I  = ACC_W'(MS_PER_S) <<< (FRAC_BITS - 1);
    localparam logic [DEN_W-1:0]        DEN_I   = DEN_W'(MS_PER_S) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] SUM_LO  = ACC_W'(DRIVE_MIN) <<< FRAC_BITS;
    localparam logic signed [ACC_W-1:0] SUM_HI  = ACC_W'(DRIVE_MAX) <<< FRAC_BITS;
    localparam logic signed [ACC_W:0]   INT_MAX = (ACC_W+1)'((65'sd1 <<< (INTEGRAL_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W:0]   INT_MIN = -INT_MAX - 1;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_OUTER = 11'b00000000010,
        S_ERR   = 11'b00000000100,
        S_PMUL  = 11'b00000001000,
        S_IMUL  = 11'b00000010000,
        S_IMS   = 11'b00000100000,
        S_IDIV  = 11'b00001000000,
        S_DMUL  = 11'b00010000000,
        S_DDIV  = 11'b00100000000,
        S_SUM   = 11'b01000000000,
        S_FIN   = 11'b10000000000
    } t_state;

    // configuration registers
    logic signed [16:0] r_setpoint;
    logic [15:0]        r_kp_outer, r_kp_inner, r_ki_inner, r_kd_inner, r_window;
    logic [10:0]        r_throttle;

    // captured beat
    logic signed [16:0] r_angle;
    logic signed [15:0] r_rate;
    logic [7:0]         r_ms;
    logic               r_inner_due;

    // loop state
    t_state                   r_state;
    logic                     r_launched;
    logic signed [31:0]       r_outer_term;
    logic signed [INTEGRAL_WIDTH-1:0] r_integral;
    logic signed [31:0]       r_last;
    logic signed [10:0]       r_held;
    logic signed [31:0]       r_e;
    logic                     r_in_win;
    logic signed [ACC_W-1:0]  r_p, r_d, r_tmp;
    logic                     r_skip;

    // output register
    logic                     r_out_valid;
    logic signed [10:0]       r_drive;
    logic [10:0]              r_pa, r_pb;
    logic                     r_out_skip;

    t_mul_req  w_mul_req;
    t_div_req  w_div_req;
    t_unit_rsp w_mul_rsp, w_div_rsp;

    logic signed [31:0]       w_e;
    logic [31:0]              w_mag;
    logic signed [ACC_W-1:0]  w_rounded;
    logic signed [ACC_W:0]    w_int_sum;
    logic signed [ACC_W-1:0]  w_sum, w_clamp;
    logic signed [12:0]       w_pa, w_pb;
    logic [10:0]              w_pa_c, w_pb_c;
    logic                     w_out_free;

    cpd_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_mul_req), .o_rsp(w_mul_rsp));
    cpd_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_div_req), .o_rsp(w_div_rsp));

    assign i_in.ready = (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || o_out.ready;

    // inner error and its window test
    assign w_e   = r_outer_term - 32'(r_rate);
    assign w_mag = w_e[31] ? 32'(-w_e) : 32'(w_e);

    assign w_rounded = (w_mul_rsp.value + HALF) >>> FRAC_BITS;
    assign w_int_sum = (ACC_W+1)'(r_integral) + (ACC_W+1)'(w_div_rsp.value);

    // PID sum, clamp to the drive range
    assign w_sum   = r_p + ACC_W'(r_integral) + r_d;
    assign w_clamp = (w_sum < SUM_LO) ? SUM_LO : ((w_sum > SUM_HI) ? SUM_HI : w_sum);

    // motor pulses from the held drive
    assign w_pa   = $signed({2'b00, r_throttle}) + 13'(r_held);
    assign w_pb   = $signed({2'b00, r_throttle}) - 13'(r_held);
    assign w_pa_c = (w_pa < 13'(PULSE_MIN)) ? 11'(PULSE_MIN)
                  : ((w_pa > 13'(PULSE_MAX)) ? 11'(PULSE_MAX) : w_pa[10:0]);
    assign w_pb_c = (w_pb < 13'(PULSE_MIN)) ? 11'(PULSE_MIN)
                  : ((w_pb > 13'(PULSE_MAX)) ? 11'(PULSE_MAX) : w_pb[10:0]);

    // unit requests per state
    always_comb begin
        w_mul_req.start = 1'b0;
        w_mul_req.a     = '0;
        w_mul_req.b     = '0;
        w_div_req.start = 1'b0;
        w_div_req.num   = '0;
        w_div_req.den   = '0;
        case (r_state)
            S_OUTER: begin
                w_mul_req.start = !r_launched;
                w_mul_req.a     = ACC_W'(r_angle) - ACC_W'(r_setpoint);
                w_mul_req.b     = r_kp_outer;
            end
            S_PMUL: begin
                w_mul_req.start = !r_launched;
                w_mul_req.a     = ACC_W'(r_e);
                w_mul_req.b     = r_kp_inner;
            end
            S_IMUL: begin
                w_mul_req.start = !r_launched;
                w_mul_req.a     = ACC_W'(r_e);
                w_mul_req.b     = r_ki_inner;
            end
            S_IMS: begin
                w_mul_req.start = !r_launched;
                w_mul_req.a     = r_tmp;
                w_mul_req.b     = MUL_B_W'(r_ms);
            end
            S_IDIV: begin
                w_div_req.start = !r_launched;
                w_div_req.num   = r_tmp + HALF_I;
                w_div_req.den   = DEN_I;
            end
            S_DMUL: begin
                w_mul_req.start = !r_launched;
                w_mul_req.a     = ACC_W'(r_e) - ACC_W'(r_last);
                w_mul_req.b     = r_kd_inner;
            end
            S_DDIV: begin
                // times 1000 as 1024 - 16 - 8
                w_div_req.start = !r_launched;
                w_div_req.num   = (r_tmp <<< 10) - (r_tmp <<< 4) - (r_tmp <<< 3)
                                + (ACC_W'(r_ms) <<< (FRAC_BITS - 1));
                w_div_req.den   = DEN_W'(r_ms) << FRAC_BITS;
            end
            default: ;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= '0;
            r_kp_outer <= 16'd3072;
            r_kp_inner <= 16'd154;
            r_ki_inner <= 16'd26;
            r_kd_inner <= 16'd51;
            r_throttle <= 11'd1300;
            r_window   <= 16'd2560;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SETPOINT: r_setpoint <= $signed(i_cfg_data);
                REG_KP_OUTER: r_kp_outer <= i_cfg_data[15:0];
                REG_KP_INNER: r_kp_inner <= i_cfg_data[15:0];
                REG_KI_INNER: r_ki_inner <= i_cfg_data[15:0];
                REG_KD_INNER: r_kd_inner <= i_cfg_data[15:0];
                REG_THROTTLE: r_throttle <= i_cfg_data[10:0];
                REG_WINDOW:   r_window   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_launched   <= 1'b0;
            r_outer_term <= '0;
            r_integral   <= '0;
            r_last       <= '0;
            r_held       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // result beat leaves; the finish state sets it again itself
            if (o_out.ready && r_state != S_FIN) r_out_valid <= 1'b0;
            if (w_mul_req.start || w_div_req.start) r_launched <= 1'b1;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_angle     <= i_in.pitch_angle;
                        r_rate      <= i_in.pitch_rate;
                        r_ms        <= i_in.elapsed_ms;
                        r_inner_due <= i_in.inner_due;
                        r_skip      <= 1'b0;
                        r_d         <= '0;
                        if (i_in.outer_due)      r_state <= S_OUTER;
                        else if (i_in.inner_due) r_state <= S_ERR;
                        else                     r_state <= S_FIN;
                    end
                end
                S_OUTER: begin
                    if (w_mul_rsp.done) begin
                        r_launched   <= 1'b0;
                        r_outer_term <= w_rounded[31:0];
                        r_state      <= r_inner_due ? S_ERR : S_FIN;
                    end
                end
                S_ERR: begin
                    r_e      <= w_e;
                    r_in_win <= (w_mag < 32'(r_window));
                    r_state  <= S_PMUL;
                end
                S_PMUL: begin
                    if (w_mul_rsp.done) begin
                        r_launched <= 1'b0;
                        r_p        <= w_rounded;
                        if (r_in_win) begin
                            r_state <= S_IMUL;
                        end else if (r_ms == '0) begin
                            r_skip  <= 1'b1;
                            r_state <= S_SUM;
                        end else begin
                            r_state <= S_DMUL;
                        end
                    end
                end
                S_IMUL, S_IMS, S_DMUL: begin
                    if (w_mul_rsp.done) begin
                        r_launched <= 1'b0;
                        r_tmp      <= w_mul_rsp.value;
                        if (r_state == S_IMUL)      r_state <= S_IMS;
                        else if (r_state == S_IMS)  r_state <= S_IDIV;
                        else                        r_state <= S_DDIV;
                    end
                end
                S_IDIV: begin
                    if (w_div_rsp.done) begin
                        r_launched <= 1'b0;
                        // saturate the integral to its width
                        if (w_int_sum > INT_MAX)
                            r_integral <= INTEGRAL_WIDTH'(INT_MAX);
                        else if (w_int_sum < INT_MIN)
                            r_integral <= INTEGRAL_WIDTH'(INT_MIN);
                        else
                            r_integral <= w_int_sum[INTEGRAL_WIDTH-1:0];
                        if (r_ms == '0) begin
                            r_skip  <= 1'b1;
                            r_state <= S_SUM;
                        end else begin
                            r_state <= S_DMUL;
                        end
                    end
                end
                S_DDIV: begin
                    if (w_div_rsp.done) begin
                        r_launched <= 1'b0;
                        r_d        <= w_div_rsp.value;
                        r_state    <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_held  <= 11'((w_clamp + HALF) >>> FRAC_BITS);
                    r_last  <= r_e;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_drive     <= r_held;
                        r_pa        <= w_pa_c;
                        r_pb        <= w_pb_c;
                        r_out_skip  <= r_skip;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.drive              = r_drive;
    assign o_out.pulse_a            = r_pa;
    assign o_out.pulse_b            = r_pb;
    assign o_out.derivative_skipped = r_out_skip;

endmodule

// ----- hw/rtl/cpd_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks on the result channel of the controller, bound to the
// top level. Depends on cpd_pkg and cascaded_pid_dual_pwm.
module cpd_checker
    import cpd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [10:0] i_drive,
    input logic [10:0]        i_pulse_a,
    input logic [10:0]        i_pulse_b
);

    // a stalled result beat holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_drive)
        && $stable(i_pulse_a) && $stable(i_pulse_b))
        else $error("result beat changed while stalled");

    // drive within its clamp
    a_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_drive >= 11'(DRIVE_MIN)) && (i_drive <= 11'(DRIVE_MAX)))
        else $error("drive out of range");

    // both pulses within their clamp
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_pulse_a >= 11'(PULSE_MIN)) && (i_pulse_a <= 11'(PULSE_MAX))
        && (i_pulse_b >= 11'(PULSE_MIN)) && (i_pulse_b <= 11'(PULSE_MAX)))
        else $error("pulse out of range");

    // zero drive gives matched pulses
    a_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_drive == '0) |-> (i_pulse_a == i_pulse_b))
        else $error("pulses differ at zero drive");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind cascaded_pid_dual_pwm cpd_checker u_cpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_drive     (o_out.drive),
    .i_pulse_a   (o_out.pulse_a),
    .i_pulse_b   (o_out.pulse_b)
);

// ----- sim/tb_cascaded_pid_dual_pwm.sv -----
`timescale 1ns / 1ps
// Testbench for the cascaded PID controller with two opposed motor pulses.
// Depends on cpd_pkg, cpd_in_if/cpd_out_if and the cascaded_pid_dual_pwm RTL.
module tb_cascaded_pid_dual_pwm;
    import cpd_pkg::*;

    localparam longint CYCLE_LIMIT = 2_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [16:0] i_cfg_data;

    cpd_in_if  in_ch ();
    cpd_out_if out_ch ();

    cascaded_pid_dual_pwm dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    typedef struct {
        logic signed [10:0] drive;
        logic [10:0]        pulse_a;
        logic [10:0]        pulse_b;
        logic               skipped;
    } t_pulse_set;

    // predictor copy of the registers and loop state
    longint  m_setpoint, m_kp_outer, m_kp_inner, m_ki_inner, m_kd_inner;
    longint  m_throttle, m_window;
    longint  m_outer, m_integ, m_last_err, m_drive;

    t_pulse_set pending_pulses[$];
    int         err_count;
    longint     cycle_count;
    bit         rx_random;
    bit         rx_hold;
    int         tx_idle_pct;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------- predictor ----------
    function automatic longint sat_sum(longint a, longint b);
        longint s;
        s = a + b;
        if (b > 0 && s < a) return 64'sh7fffffffffffffff;
        if (b < 0 && s > a) return 64'sh8000000000000000;
        return s;
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    // round to nearest, ties toward plus infinity
    function automatic longint round_div(longint x, longint d);
        longint y, q;
        y = x + d / 2;
        q = y / d;
        if ((y % d) != 0 && y < 0) q -= 1;
        return q;
    endfunction

    function automatic void model_config(int idx, logic [16:0] val);
        case (idx)
            REG_SETPOINT: m_setpoint = longint'($signed(val));
            REG_KP_OUTER: m_kp_outer = longint'(val[15:0]);
            REG_KP_INNER: m_kp_inner = longint'(val[15:0]);
            REG_KI_INNER: m_ki_inner = longint'(val[15:0]);
            REG_KD_INNER: m_kd_inner = longint'(val[15:0]);
            REG_THROTTLE: m_throttle = longint'(val[10:0]);
            REG_WINDOW:   m_window   = longint'(val[15:0]);
            default: ;
        endcase
    endfunction

    function automatic t_pulse_set predict_pass(logic signed [16:0] ang,
            logic signed [15:0] rate, logic [7:0] ms_in, logic od, logic id);
        t_pulse_set r;
        longint one, ms, e, p, mag, d, s, inc, imax;
        one = 64'sd1 <<< FRAC_BITS;
        ms = longint'(ms_in);
        imax = (64'sd1 <<< (INTEGRAL_WIDTH - 1)) - 1;
        r.skipped = 1'b0;
        if (od)
            m_outer = clip(round_div(m_kp_outer * (longint'(ang) - m_setpoint), one),
                           -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
        if (id) begin
            e = clip(m_outer - longint'(rate), -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
            p = round_div(m_kp_inner * e, one);
            mag = e < 0 ? -e : e;
            d = 0;
            if (mag < m_window) begin
                inc = round_div(m_ki_inner * e * ms, MS_PER_S * one);
                m_integ = clip(sat_sum(m_integ, inc), -imax - 1, imax);
            end
            if (ms == 0) r.skipped = 1'b1;
            else d = round_div(m_kd_inner * (e - m_last_err) * MS_PER_S, ms * one);
            s = sat_sum(sat_sum(p, m_integ), d);
            s = clip(s, DRIVE_MIN * one, DRIVE_MAX * one);
            m_drive = round_div(s, one);
            m_last_err = e;
        end
        r.drive   = m_drive[10:0];
        r.pulse_a = 11'(clip(m_throttle + m_drive, PULSE_MIN, PULSE_MAX));
        r.pulse_b = 11'(clip(m_throttle - m_drive, PULSE_MIN, PULSE_MAX));
        return r;
    endfunction

    // ---------- stimulus helpers ----------
    // valid stays up after an accepted beat so that beats can follow back to back;
    // an idle cycle or the drain wait takes it down
    task automatic send_pass(logic signed [16:0] ang, logic signed [15:0] rate,
            logic [7:0] ms, logic od, logic id);
        while (tx_idle_pct > 0 && $urandom_range(99, 0) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.pitch_angle <= ang;
        in_ch.pitch_rate  <= rate;
        in_ch.elapsed_ms  <= ms;
        in_ch.outer_due   <= od;
        in_ch.inner_due   <= id;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_pulses.push_back(predict_pass(ang, rate, ms, od, id));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_pulses.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [16:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        model_config(idx, val);
    endtask

    // random in-range angle mostly, full width sometimes
    function automatic logic signed [16:0] rand_angle();
        if ($urandom_range(9, 0) == 0) return 17'($urandom);
        return 17'($signed($urandom_range(92160, 0)) - 46080);
    endfunction

    task automatic send_random(int n);
        logic [7:0] ms;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(3, 0))
                0: ms = 8'd0;
                1: ms = 8'($urandom);
                default: ms = 8'($urandom_range(5, 1));
            endcase
            send_pass(rand_angle(), ($urandom_range(3, 0) == 0) ? 16'($urandom)
                      : 16'($signed($urandom_range(2048, 0)) - 1024), ms,
                      ($urandom_range(4, 0) == 0), ($urandom_range(5, 0) != 0));
        end
    endtask

    // ---------- tests ----------
    task automatic test_reset_defaults();
        send_pass(17'sd0, 16'sd0, 8'd1, 1'b1, 1'b1);
        send_pass(17'sd256, 16'sd0, 8'd4, 1'b1, 1'b1);
        send_pass(17'sd0, 16'sd0, 8'd4, 1'b0, 1'b0);
        wait_drained();
    endtask

    task automatic test_field_extremes();
        send_pass(17'sd46080, 16'sd32767, 8'd255, 1'b1, 1'b1);
        send_pass(-17'sd46080, -16'sd32768, 8'd1, 1'b1, 1'b1);
        send_pass(17'h0ffff, 16'sd0, 8'd0, 1'b1, 1'b1);      // zero elapsed time
        send_pass(17'h10000, 16'sd100, 8'd0, 1'b1, 1'b1);
        send_pass(17'sd0, 16'sd5, 8'd10, 1'b0, 1'b1);        // outer held
        send_pass(17'sd0, 16'sd5, 8'd10, 1'b1, 1'b0);        // inner held
        send_pass(17'sd0, 16'sd0, 8'd0, 1'b0, 1'b0);
        send_pass(17'sd1000, -16'sd1, 8'd2, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_gain_extremes();
        write_reg(REG_KP_OUTER, 17'h0ffff);
        write_reg(REG_KP_INNER, 17'h0ffff);
        write_reg(REG_KI_INNER, 17'h0ffff);
        write_reg(REG_KD_INNER, 17'h0ffff);
        write_reg(REG_WINDOW, 17'h0ffff);
        write_reg(REG_SETPOINT, 17'sd46080);
        write_reg(REG_THROTTLE, 17'd2000);
        send_pass(-17'sd46080, 16'sd32767, 8'd255, 1'b1, 1'b1);
        send_pass(17'sd46080, -16'sd32768, 8'd1, 1'b1, 1'b1);
        send_pass(17'sd0, 16'sd0, 8'd0, 1'b1, 1'b1);
        wait_drained();
        write_reg(REG_KP_OUTER, 17'd0);
        write_reg(REG_KP_INNER, 17'd0);
        write_reg(REG_KI_INNER, 17'd0);
        write_reg(REG_KD_INNER, 17'd0);
        write_reg(REG_WINDOW, 17'd0);
        write_reg(REG_SETPOINT, -17'sd46080);
        write_reg(REG_THROTTLE, 17'd1000);
        send_pass(17'sd46080, 16'sd1, 8'd3, 1'b1, 1'b1);
        send_pass(17'sd0, 16'sd0, 8'd3, 1'b1, 1'b1);
        wait_drained();
        // out-of-range throttle values, unknown register index
        write_reg(REG_THROTTLE, 17'h7ff);
        write_reg(3'd7, 17'h1ffff);
        send_pass(17'sd0, 16'sd0, 8'd1, 1'b0, 1'b0);
        wait_drained();
        write_reg(REG_THROTTLE, 17'd0);
        send_pass(17'sd0, 16'sd0, 8'd1, 1'b0, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_SETPOINT, 17'($signed($urandom_range(92160, 0)) - 46080));
            write_reg(REG_KP_OUTER, 17'($urandom_range(ph[0] ? 65535 : 4096, 0)));
            write_reg(REG_KP_INNER, 17'($urandom_range(ph[1] ? 65535 : 1024, 0)));
            write_reg(REG_KI_INNER, 17'($urandom_range(ph[2] ? 65535 : 512, 0)));
            write_reg(REG_KD_INNER, 17'($urandom_range(ph[0] ? 65535 : 256, 0)));
            write_reg(REG_THROTTLE, 17'($urandom_range(2047, 0)));
            write_reg(REG_WINDOW, 17'($urandom));
            tx_idle_pct = (ph == 3) ? 0 : 34;
            rx_random   = (ph != 3);
            send_random(100);
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        rx_hold = 1'b1;
        fork
            begin
                repeat (800) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            send_random(40);
        join
        wait_drained();
        // sender pauses until everything has come back, then resumes
        send_random(60);
        wait_drained();
        send_random(80);
        wait_drained();
    endtask

    // ---------- receiver and checker ----------
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= !rx_hold && (!rx_random || $urandom_range(99, 0) >= 34);
    end

    always @(posedge i_clk) begin
        t_pulse_set exp_set;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_pulses.size() == 0) begin
                $error("result beat with no expectation pending");
                err_count++;
            end else begin
                exp_set = pending_pulses.pop_front();
                if (out_ch.drive !== exp_set.drive) begin
                    $error("drive: expected %0d, got %0d", exp_set.drive, out_ch.drive);
                    err_count++;
                end
                if (out_ch.pulse_a !== exp_set.pulse_a) begin
                    $error("pulse_a: expected %0d, got %0d", exp_set.pulse_a,
                           out_ch.pulse_a);
                    err_count++;
                end
                if (out_ch.pulse_b !== exp_set.pulse_b) begin
                    $error("pulse_b: expected %0d, got %0d", exp_set.pulse_b,
                           out_ch.pulse_b);
                    err_count++;
                end
                if (out_ch.derivative_skipped !== exp_set.skipped) begin
                    $error("derivative_skipped: expected %0d, got %0d",
                           exp_set.skipped, out_ch.derivative_skipped);
                    err_count++;
                end
            end
        end
    end

    // run-length watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.pitch_angle = '0;
        in_ch.pitch_rate = '0;
        in_ch.elapsed_ms = '0;
        in_ch.outer_due = 1'b0;
        in_ch.inner_due = 1'b0;
        err_count = 0;
        cycle_count = 0;
        rx_random = 1'b1;
        rx_hold = 1'b0;
        tx_idle_pct = 34;
        m_setpoint = 0; m_kp_outer = 3072; m_kp_inner = 154; m_ki_inner = 26;
        m_kd_inner = 51; m_throttle = 1300; m_window = 2560;
        m_outer = 0; m_integ = 0; m_last_err = 0; m_drive = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_field_extremes();
        test_gain_extremes();
        test_random_settings();
        test_backpressure();

        wait_drained();
        if (err_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
